// File: rtl/dllm_pkg.sv
// ----------------------------------------------------------------------------
// Doubly linked list manager package
// Shared constants, codes, microcode word layout and control structs.
// ----------------------------------------------------------------------------
package dllm_pkg;

   localparam int POOL_SIZE = 64;
   localparam int IDX_W     = $clog2(POOL_SIZE);
   localparam int LINK_W    = IDX_W + 1;
   localparam int CNT_W     = $clog2(POOL_SIZE + 1);
   localparam int OP_W      = 3;
   localparam int STATUS_W  = 2;
   localparam int CSR_IDX_W = 1;
   localparam int UADDR_W   = 5;

   typedef logic [LINK_W-1:0] link_type;

   localparam link_type LINK_NIL = LINK_W'(POOL_SIZE);
   localparam logic [CNT_W-1:0] LIMIT_RESET = CNT_W'(64);

   typedef enum logic [OP_W-1:0] {
      OP_INS_HEAD   = 3'd0,
      OP_INS_TAIL   = 3'd1,
      OP_INS_AFTER  = 3'd2,
      OP_INS_BEFORE = 3'd3,
      OP_POP_HEAD   = 3'd4,
      OP_POP_TAIL   = 3'd5,
      OP_DELETE     = 3'd6
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_LIMIT_ENABLE = 1'd0,
      CSR_NODE_LIMIT   = 1'd1
   } csr_idx_type;

   typedef enum logic [UADDR_W-1:0] {
      U_NOP, U_FULL, U_EMPTY,
      U_IH0, U_IH1, U_IH2, U_IHE,
      U_IT0, U_IT1, U_IT2, U_ITE,
      U_IA0, U_IA1, U_IA2, U_IAE,
      U_IB0, U_IB1, U_IB2, U_IBE,
      U_PH0, U_PH1, U_PH2, U_PHE,
      U_PT0, U_PT1, U_PT2, U_PTE,
      U_DL0, U_DL1, U_DL2
   } uaddr_type;

   typedef enum logic [1:0] {MEM_IDLE, MEM_READ, MEM_WRITE} mem_op_type;

   typedef enum logic [2:0] {
      SRC_N, SRC_A, SRC_HEAD, SRC_TAIL, SRC_NRD, SRC_PRD, SRC_NIL
   } src_type;

   typedef enum logic [2:0] {HD_KEEP, HD_N, HD_NIL, HD_NRD, HD_DEL} head_sel_type;
   typedef enum logic [2:0] {TL_KEEP, TL_N, TL_NIL, TL_PRD, TL_DEL} tail_sel_type;

   typedef enum logic [2:0] {
      CND_NONE, CND_ALWAYS, CND_HEAD_NIL, CND_TAIL_NIL, CND_NRD_NIL, CND_PRD_NIL
   } cond_type;

   typedef enum logic [1:0] {CNT_HOLD, CNT_INC, CNT_DEC} cnt_type;
   typedef enum logic [1:0] {REM_NONE, REM_HEAD, REM_TAIL} rem_type;

   typedef struct packed {
      mem_op_type   nxt_op;
      src_type      nxt_addr;
      src_type      nxt_data;
      mem_op_type   prv_op;
      src_type      prv_addr;
      src_type      prv_data;
      head_sel_type head_sel;
      tail_sel_type tail_sel;
      cond_type     cond;
      uaddr_type    target;
      logic         done;
      cnt_type      cnt;
      rem_type      rem;
      status_type   status;
   } ctrl_type;

   localparam ctrl_type CTRL_NONE = '{
      nxt_op:   MEM_IDLE,
      nxt_addr: SRC_NIL,
      nxt_data: SRC_NIL,
      prv_op:   MEM_IDLE,
      prv_addr: SRC_NIL,
      prv_data: SRC_NIL,
      head_sel: HD_KEEP,
      tail_sel: TL_KEEP,
      cond:     CND_NONE,
      target:   U_NOP,
      done:     1'b0,
      cnt:      CNT_HOLD,
      rem:      REM_NONE,
      status:   ST_OK
   };

   typedef struct packed {
      logic head_nil;
      logic tail_nil;
      logic nrd_nil;
      logic prd_nil;
      logic ins_refused;
      logic list_empty;
      logic rsp_hold;
   } dp_flags_type;

   typedef struct packed {
      logic step_en;
      logic accept;
   } seq_ctl_type;

endpackage

// File: rtl/dllm_req_if.sv
// ----------------------------------------------------------------------------
// Request channel
// Carries one list operation with its node and anchor slots.
// ----------------------------------------------------------------------------
interface dllm_req_if import dllm_pkg::*; ();

   logic             valid;
   logic             ready;
   logic [OP_W-1:0]  op;
   logic [IDX_W-1:0] node_index;
   logic [IDX_W-1:0] anchor_index;

   modport source (output valid, output op, output node_index, output anchor_index,
                   input ready);
   modport sink (input valid, input op, input node_index, input anchor_index,
                 output ready);

endinterface

// File: rtl/dllm_rsp_if.sv
// ----------------------------------------------------------------------------
// Response channel
// Carries the status, removed slot and node count of one operation.
// ----------------------------------------------------------------------------
interface dllm_rsp_if import dllm_pkg::*; ();

   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [IDX_W-1:0]    removed_index;
   logic [CNT_W-1:0]    node_count;

   modport source (output valid, output status, output removed_index,
                   output node_count, input ready);
   modport sink (input valid, input status, input removed_index,
                 input node_count, output ready);

endinterface

// File: rtl/dllm_csr_if.sv
// ----------------------------------------------------------------------------
// Configuration write channel
// Carries a register index and the data written to it.
// ----------------------------------------------------------------------------
interface dllm_csr_if import dllm_pkg::*; ();

   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [CNT_W-1:0]     data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);

endinterface

// File: rtl/doubly_linked_list_manager_unit.sv
// ----------------------------------------------------------------------------
// Doubly linked list manager
// Keeps a doubly linked list over a pool of node slots and answers every
// request with one response. Insert at head, insert at tail, insert after or
// before an anchor, pop of either end and delete each run a three-step
// microprogram, because every step does at most one access to each of the
// two single-port link memories; an insert refused as full, a pop or delete
// on an empty list and an unused op code take one step. A new request
// transfer is taken in the cycle of the last step of the previous one. A
// finished response waits in an output register and does not hold up the
// next request until its own last step. Configuration must be written
// only while the block is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module doubly_linked_list_manager_unit import dllm_pkg::*; (
   input logic      clock,
   input logic      reset,
   dllm_req_if.sink   req_bus,
   dllm_rsp_if.source rsp_bus,
   dllm_csr_if.sink   csr_bus
);

   uaddr_type    upc;
   ctrl_type     ctrl;
   dp_flags_type flags;
   seq_ctl_type  seq;
   logic         req_ready;
   logic         rsp_valid;
   logic [STATUS_W-1:0] rsp_status;
   logic [IDX_W-1:0]    rsp_removed;
   logic [CNT_W-1:0]    rsp_count;

   dllm_ucode_rom u_rom (
      .upc  (upc),
      .ctrl (ctrl)
   );

   dllm_sequencer u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_op    (req_bus.op),
      .req_ready (req_ready),
      .ctrl      (ctrl),
      .flags     (flags),
      .upc       (upc),
      .seq       (seq)
   );

   dllm_datapath u_dp (
      .clock       (clock),
      .reset       (reset),
      .ctrl        (ctrl),
      .seq         (seq),
      .req_node    (req_bus.node_index),
      .req_anchor  (req_bus.anchor_index),
      .csr_we      (csr_bus.valid),
      .csr_index   (csr_bus.index),
      .csr_data    (csr_bus.data),
      .rsp_ready   (rsp_bus.ready),
      .rsp_valid   (rsp_valid),
      .rsp_status  (rsp_status),
      .rsp_removed (rsp_removed),
      .rsp_count   (rsp_count),
      .flags       (flags)
   );

   assign req_bus.ready         = req_ready;
   assign csr_bus.ready         = 1'b1;
   assign rsp_bus.valid         = rsp_valid;
   assign rsp_bus.status        = rsp_status;
   assign rsp_bus.removed_index = rsp_removed;
   assign rsp_bus.node_count    = rsp_count;

endmodule

// File: rtl/dllm_link_ram.sv
// ----------------------------------------------------------------------------
// Link memory
// Single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module dllm_link_ram #(
   parameter int DEPTH  = 64,
   parameter int WIDTH  = 7,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              en,
   input  logic              we,
   input  logic [ADDR_W-1:0] addr,
   input  logic [WIDTH-1:0]  wdata,
   output logic [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            mem_ff[addr] <= wdata;
         end else begin
            rdata_ff <= mem_ff[addr];
         end
      end
   end

   assign rdata = rdata_ff;

endmodule

// File: rtl/dllm_ucode_rom.sv
// ----------------------------------------------------------------------------
// Microcode ROM
// One control word per step of each list operation.
// ----------------------------------------------------------------------------
module dllm_ucode_rom import dllm_pkg::*; (
   input  uaddr_type upc,
   output ctrl_type  ctrl
);

   always_comb begin
      ctrl = CTRL_NONE;
      case (upc)
         U_NOP: begin
            ctrl.done = 1'b1;
         end
         U_FULL: begin
            ctrl.done   = 1'b1;
            ctrl.status = ST_FULL;
         end
         U_EMPTY: begin
            ctrl.done   = 1'b1;
            ctrl.status = ST_EMPTY;
         end
         U_IH0: begin
            ctrl.cond   = CND_HEAD_NIL;
            ctrl.target = U_IHE;
         end
         U_IH1: begin
            ctrl.nxt_op   = MEM_WRITE;
            ctrl.nxt_addr = SRC_N;
            ctrl.nxt_data = SRC_HEAD;
            ctrl.prv_op   = MEM_WRITE;
            ctrl.prv_addr = SRC_HEAD;
            ctrl.prv_data = SRC_N;
            ctrl.head_sel = HD_N;
         end
         U_IH2: begin
            ctrl.prv_op   = MEM_WRITE;
            ctrl.prv_addr = SRC_N;
            ctrl.prv_data = SRC_NIL;
            ctrl.done     = 1'b1;
            ctrl.cnt      = CNT_INC;
         end
         U_IHE: begin
            ctrl.nxt_op   = MEM_WRITE;
            ctrl.nxt_addr = SRC_N;
            ctrl.nxt_data = SRC_NIL;
            ctrl.head_sel = HD_N;
            ctrl.tail_sel = TL_N;
            ctrl.cond     = CND_ALWAYS;
            ctrl.target   = U_IH2;
         end
         U_IT0: begin
            ctrl.cond   = CND_TAIL_NIL;
            ctrl.target = U_ITE;
         end
         U_IT1: begin
            ctrl.prv_op   = MEM_WRITE;
            ctrl.prv_addr = SRC_N;
            ctrl.prv_data = SRC_TAIL;
            ctrl.nxt_op   = MEM_WRITE;
            ctrl.nxt_addr = SRC_TAIL;
            ctrl.nxt_data = SRC_N;
            ctrl.tail_sel = TL_N;
         end
         U_IT2: begin
            ctrl.nxt_op   = MEM_WRITE;
            ctrl.nxt_addr = SRC_N;
            ctrl.nxt_data = SRC_NIL;
            ctrl.done     = 1'b1;
            ctrl.cnt      = CNT_INC;
         end
         U_ITE: begin
            ctrl.prv_op   = MEM_WRITE;
            ctrl.prv_addr = SRC_N;
            ctrl.prv_data = SRC_NIL;
            ctrl.head_sel = HD_N;
            ctrl.tail_sel = TL_N;
            ctrl.cond     = CND_ALWAYS;
            ctrl.target   = U_IT2;
         end
         U_IA0: begin
            ctrl.nxt_op   = MEM_READ;
            ctrl.nxt_addr = SRC_A;
         end
         U_IA1: begin
            ctrl.nxt_op   = MEM_WRITE;
            ctrl.nxt_addr = SRC_A;
            ctrl.nxt_data = SRC_N;
            ctrl.prv_op   = MEM_WRITE;
            ctrl.prv_addr = SRC_N;
            ctrl.prv_data = SRC_A;
            ctrl.cond     = CND_NRD_NIL;
            ctrl.target   = U_IAE;
         end
         U_IA2: begin
            ctrl.nxt_op   = MEM_WRITE;
            ctrl.nxt_addr = SRC_N;
            ctrl.nxt_data = SRC_NRD;
            ctrl.prv_op   = MEM_WRITE;
            ctrl.prv_addr = SRC_NRD;
            ctrl.prv_data = SRC_N;
            ctrl.done     = 1'b1;
            ctrl.cnt      = CNT_INC;
         end
         U_IAE: begin
            ctrl.nxt_op   = MEM_WRITE;
            ctrl.nxt_addr = SRC_N;
            ctrl.nxt_data = SRC_NRD;
            ctrl.tail_sel = TL_N;
            ctrl.done     = 1'b1;
            ctrl.cnt      = CNT_INC;
         end
         U_IB0: begin
            ctrl.prv_op   = MEM_READ;
            ctrl.prv_addr = SRC_A;
         end
         U_IB1: begin
            ctrl.prv_op   = MEM_WRITE;
            ctrl.prv_addr = SRC_A;
            ctrl.prv_data = SRC_N;
            ctrl.nxt_op   = MEM_WRITE;
            ctrl.nxt_addr = SRC_N;
            ctrl.nxt_data = SRC_A;
            ctrl.cond     = CND_PRD_NIL;
            ctrl.target   = U_IBE;
         end
         U_IB2: begin
            ctrl.prv_op   = MEM_WRITE;
            ctrl.prv_addr = SRC_N;
            ctrl.prv_data = SRC_PRD;
            ctrl.nxt_op   = MEM_WRITE;
            ctrl.nxt_addr = SRC_PRD;
            ctrl.nxt_data = SRC_N;
            ctrl.done     = 1'b1;
            ctrl.cnt      = CNT_INC;
         end
         U_IBE: begin
            ctrl.prv_op   = MEM_WRITE;
            ctrl.prv_addr = SRC_N;
            ctrl.prv_data = SRC_PRD;
            ctrl.head_sel = HD_N;
            ctrl.done     = 1'b1;
            ctrl.cnt      = CNT_INC;
         end
         U_PH0: begin
            ctrl.nxt_op   = MEM_READ;
            ctrl.nxt_addr = SRC_HEAD;
         end
         U_PH1: begin
            ctrl.cond   = CND_NRD_NIL;
            ctrl.target = U_PHE;
         end
         U_PH2: begin
            ctrl.prv_op   = MEM_WRITE;
            ctrl.prv_addr = SRC_NRD;
            ctrl.prv_data = SRC_NIL;
            ctrl.nxt_op   = MEM_WRITE;
            ctrl.nxt_addr = SRC_HEAD;
            ctrl.nxt_data = SRC_NIL;
            ctrl.head_sel = HD_NRD;
            ctrl.done     = 1'b1;
            ctrl.cnt      = CNT_DEC;
            ctrl.rem      = REM_HEAD;
         end
         U_PHE: begin
            ctrl.nxt_op   = MEM_WRITE;
            ctrl.nxt_addr = SRC_HEAD;
            ctrl.nxt_data = SRC_NIL;
            ctrl.head_sel = HD_NIL;
            ctrl.tail_sel = TL_NIL;
            ctrl.done     = 1'b1;
            ctrl.cnt      = CNT_DEC;
            ctrl.rem      = REM_HEAD;
         end
         U_PT0: begin
            ctrl.prv_op   = MEM_READ;
            ctrl.prv_addr = SRC_TAIL;
         end
         U_PT1: begin
            ctrl.cond   = CND_PRD_NIL;
            ctrl.target = U_PTE;
         end
         U_PT2: begin
            ctrl.nxt_op   = MEM_WRITE;
            ctrl.nxt_addr = SRC_PRD;
            ctrl.nxt_data = SRC_NIL;
            ctrl.prv_op   = MEM_WRITE;
            ctrl.prv_addr = SRC_TAIL;
            ctrl.prv_data = SRC_NIL;
            ctrl.tail_sel = TL_PRD;
            ctrl.done     = 1'b1;
            ctrl.cnt      = CNT_DEC;
            ctrl.rem      = REM_TAIL;
         end
         U_PTE: begin
            ctrl.prv_op   = MEM_WRITE;
            ctrl.prv_addr = SRC_TAIL;
            ctrl.prv_data = SRC_NIL;
            ctrl.head_sel = HD_NIL;
            ctrl.tail_sel = TL_NIL;
            ctrl.done     = 1'b1;
            ctrl.cnt      = CNT_DEC;
            ctrl.rem      = REM_TAIL;
         end
         U_DL0: begin
            ctrl.nxt_op   = MEM_READ;
            ctrl.nxt_addr = SRC_N;
            ctrl.prv_op   = MEM_READ;
            ctrl.prv_addr = SRC_N;
         end
         U_DL1: begin
            ctrl.prv_op   = MEM_WRITE;
            ctrl.prv_addr = SRC_NRD;
            ctrl.prv_data = SRC_PRD;
            ctrl.nxt_op   = MEM_WRITE;
            ctrl.nxt_addr = SRC_PRD;
            ctrl.nxt_data = SRC_NRD;
            ctrl.head_sel = HD_DEL;
            ctrl.tail_sel = TL_DEL;
         end
         U_DL2: begin
            ctrl.nxt_op   = MEM_WRITE;
            ctrl.nxt_addr = SRC_N;
            ctrl.nxt_data = SRC_NIL;
            ctrl.prv_op   = MEM_WRITE;
            ctrl.prv_addr = SRC_N;
            ctrl.prv_data = SRC_NIL;
            ctrl.done     = 1'b1;
            ctrl.cnt      = CNT_DEC;
         end
         default: begin
            ctrl.done = 1'b1;
         end
      endcase
   end

endmodule

// File: rtl/dllm_sequencer.sv
// ----------------------------------------------------------------------------
// Microcode sequencer
// Dispatches each request to its routine and steps the program counter.
// ----------------------------------------------------------------------------
module dllm_sequencer import dllm_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   input  logic [OP_W-1:0] req_op,
   output logic            req_ready,
   input  ctrl_type        ctrl,
   input  dp_flags_type    flags,
   output uaddr_type       upc,
   output seq_ctl_type     seq
);

   logic      busy_ff;
   logic      busy_in;
   uaddr_type upc_ff;
   uaddr_type upc_in;
   uaddr_type entry;
   logic      jump;
   logic      step_en;
   logic      accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         upc_ff  <= U_NOP;
      end else begin
         busy_ff <= busy_in;
         upc_ff  <= upc_in;
      end
   end

   always_comb begin
      case (ctrl.cond)
         CND_ALWAYS:   jump = 1'b1;
         CND_HEAD_NIL: jump = flags.head_nil;
         CND_TAIL_NIL: jump = flags.tail_nil;
         CND_NRD_NIL:  jump = flags.nrd_nil;
         CND_PRD_NIL:  jump = flags.prd_nil;
         default:      jump = 1'b0;
      endcase

      case (op_type'(req_op))
         OP_INS_HEAD:   entry = flags.ins_refused ? U_FULL : U_IH0;
         OP_INS_TAIL:   entry = flags.ins_refused ? U_FULL : U_IT0;
         OP_INS_AFTER:  entry = flags.ins_refused ? U_FULL : U_IA0;
         OP_INS_BEFORE: entry = flags.ins_refused ? U_FULL : U_IB0;
         OP_POP_HEAD:   entry = flags.list_empty ? U_EMPTY : U_PH0;
         OP_POP_TAIL:   entry = flags.list_empty ? U_EMPTY : U_PT0;
         OP_DELETE:     entry = flags.list_empty ? U_EMPTY : U_DL0;
         default:       entry = U_NOP;
      endcase

      step_en   = busy_ff && !(ctrl.done && flags.rsp_hold);
      req_ready = !busy_ff || (ctrl.done && !flags.rsp_hold);
      accept    = req_valid && req_ready;

      if (accept) begin
         upc_in = entry;
      end else if (step_en) begin
         upc_in = jump ? ctrl.target : uaddr_type'(upc_ff + 1'b1);
      end else begin
         upc_in = upc_ff;
      end

      if (accept) begin
         busy_in = 1'b1;
      end else if (step_en && ctrl.done) begin
         busy_in = 1'b0;
      end else begin
         busy_in = busy_ff;
      end
   end

   assign upc         = upc_ff;
   assign seq.step_en = step_en;
   assign seq.accept  = accept;

endmodule

// File: rtl/dllm_datapath.sv
// ----------------------------------------------------------------------------
// List datapath
// Link memories, head, tail, node count, settings and response register.
// ----------------------------------------------------------------------------
module dllm_datapath import dllm_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  ctrl_type             ctrl,
   input  seq_ctl_type          seq,
   input  logic [IDX_W-1:0]     req_node,
   input  logic [IDX_W-1:0]     req_anchor,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CNT_W-1:0]     csr_data,
   input  logic                 rsp_ready,
   output logic                 rsp_valid,
   output logic [STATUS_W-1:0]  rsp_status,
   output logic [IDX_W-1:0]     rsp_removed,
   output logic [CNT_W-1:0]     rsp_count,
   output dp_flags_type         flags
);

   link_type            n_ff;
   link_type            a_ff;
   link_type            head_ff;
   link_type            head_in;
   link_type            tail_ff;
   link_type            tail_in;
   logic [CNT_W-1:0]    cnt_ff;
   logic [CNT_W-1:0]    cnt_in;
   logic                limit_en_ff;
   logic [CNT_W-1:0]    limit_ff;
   logic                nrd_nil_ff;
   logic                prd_nil_ff;
   link_type            nxt_q;
   link_type            prv_q;
   link_type            nrd;
   link_type            prd;
   link_type            nxt_addr;
   link_type            nxt_wdata;
   link_type            prv_addr;
   link_type            prv_wdata;
   logic                nxt_en;
   logic                nxt_we;
   logic                prv_en;
   logic                prv_we;
   logic                rsp_valid_ff;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic [IDX_W-1:0]    rsp_removed_ff;
   logic [CNT_W-1:0]    rsp_count_ff;
   logic                finish;

   function automatic logic is_nil(input link_type l);
      return l >= LINK_NIL;
   endfunction

   function automatic link_type pick(input src_type s, input link_type n, input link_type a,
                                     input link_type h, input link_type t,
                                     input link_type x, input link_type p);
      link_type v;
      case (s)
         SRC_N:    v = n;
         SRC_A:    v = a;
         SRC_HEAD: v = h;
         SRC_TAIL: v = t;
         SRC_NRD:  v = x;
         SRC_PRD:  v = p;
         default:  v = LINK_NIL;
      endcase
      return v;
   endfunction

   assign nrd    = nrd_nil_ff ? LINK_NIL : nxt_q;
   assign prd    = prd_nil_ff ? LINK_NIL : prv_q;
   assign finish = seq.step_en && ctrl.done;

   always_comb begin
      nxt_addr  = pick(ctrl.nxt_addr, n_ff, a_ff, head_ff, tail_ff, nrd, prd);
      nxt_wdata = pick(ctrl.nxt_data, n_ff, a_ff, head_ff, tail_ff, nrd, prd);
      prv_addr  = pick(ctrl.prv_addr, n_ff, a_ff, head_ff, tail_ff, nrd, prd);
      prv_wdata = pick(ctrl.prv_data, n_ff, a_ff, head_ff, tail_ff, nrd, prd);

      nxt_en = seq.step_en && (ctrl.nxt_op != MEM_IDLE) && !is_nil(nxt_addr);
      nxt_we = ctrl.nxt_op == MEM_WRITE;
      prv_en = seq.step_en && (ctrl.prv_op != MEM_IDLE) && !is_nil(prv_addr);
      prv_we = ctrl.prv_op == MEM_WRITE;

      head_in = head_ff;
      if (seq.step_en) begin
         case (ctrl.head_sel)
            HD_N:    head_in = n_ff;
            HD_NIL:  head_in = LINK_NIL;
            HD_NRD:  head_in = nrd;
            HD_DEL:  head_in = is_nil(prd) ? nrd : head_ff;
            default: head_in = head_ff;
         endcase
      end

      tail_in = tail_ff;
      if (seq.step_en) begin
         case (ctrl.tail_sel)
            TL_N:    tail_in = n_ff;
            TL_NIL:  tail_in = LINK_NIL;
            TL_PRD:  tail_in = prd;
            TL_DEL:  tail_in = is_nil(nrd) ? prd : tail_ff;
            default: tail_in = tail_ff;
         endcase
      end

      cnt_in = cnt_ff;
      if (seq.step_en) begin
         case (ctrl.cnt)
            CNT_INC: cnt_in = cnt_ff + CNT_W'(1);
            CNT_DEC: cnt_in = cnt_ff - CNT_W'(1);
            default: cnt_in = cnt_ff;
         endcase
      end

      flags.head_nil    = is_nil(head_ff);
      flags.tail_nil    = is_nil(tail_ff);
      flags.nrd_nil     = is_nil(nrd);
      flags.prd_nil     = is_nil(prd);
      flags.ins_refused = (cnt_in >= CNT_W'(POOL_SIZE))
                          || (limit_en_ff && (cnt_in >= limit_ff));
      flags.list_empty  = cnt_in == '0;
      flags.rsp_hold    = rsp_valid_ff && !rsp_ready;
   end

   dllm_link_ram #(
      .DEPTH (POOL_SIZE),
      .WIDTH (LINK_W)
   ) u_next_ram (
      .clock (clock),
      .en    (nxt_en),
      .we    (nxt_we),
      .addr  (nxt_addr[IDX_W-1:0]),
      .wdata (nxt_wdata),
      .rdata (nxt_q)
   );

   dllm_link_ram #(
      .DEPTH (POOL_SIZE),
      .WIDTH (LINK_W)
   ) u_prev_ram (
      .clock (clock),
      .en    (prv_en),
      .we    (prv_we),
      .addr  (prv_addr[IDX_W-1:0]),
      .wdata (prv_wdata),
      .rdata (prv_q)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= LINK_NIL;
         tail_ff      <= LINK_NIL;
         cnt_ff       <= '0;
         limit_en_ff  <= 1'b0;
         limit_ff     <= LIMIT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         head_ff <= head_in;
         tail_ff <= tail_in;
         cnt_ff  <= cnt_in;
         if (csr_we) begin
            case (csr_idx_type'(csr_index))
               CSR_LIMIT_ENABLE: limit_en_ff <= csr_data[0];
               CSR_NODE_LIMIT:   limit_ff    <= csr_data;
               default:          limit_ff    <= limit_ff;
            endcase
         end
         if (finish) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (seq.accept) begin
         n_ff <= {1'b0, req_node};
         a_ff <= {1'b0, req_anchor};
      end
      if (seq.step_en && (ctrl.nxt_op == MEM_READ)) begin
         nrd_nil_ff <= is_nil(nxt_addr);
      end
      if (seq.step_en && (ctrl.prv_op == MEM_READ)) begin
         prd_nil_ff <= is_nil(prv_addr);
      end
      if (finish) begin
         rsp_status_ff <= ctrl.status;
         rsp_count_ff  <= cnt_in;
         case (ctrl.rem)
            REM_HEAD: rsp_removed_ff <= head_ff[IDX_W-1:0];
            REM_TAIL: rsp_removed_ff <= tail_ff[IDX_W-1:0];
            default:  rsp_removed_ff <= '0;
         endcase
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_status  = rsp_status_ff;
   assign rsp_removed = rsp_removed_ff;
   assign rsp_count   = rsp_count_ff;

endmodule
